>>> hdl/efalu_pkg.sv
// ----------------------------------------------------------------------------
// efalu_pkg
// operation codes, constants and binary32 arithmetic for the elementwise alu
// ----------------------------------------------------------------------------
package efalu_pkg;

    typedef enum logic [3:0] {
        FUNC_ADD = 4'd0,
        FUNC_SUB = 4'd1,
        FUNC_MUL = 4'd2,
        FUNC_LT  = 4'd3,
        FUNC_GT  = 4'd4,
        FUNC_EQ  = 4'd5,
        FUNC_AND = 4'd6,
        FUNC_OR  = 4'd7,
        FUNC_NOT = 4'd8,
        FUNC_SEL = 4'd9
    } t_func;

    localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
    localparam logic [31:0] FP_ZERO = 32'h0000_0000;
    localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;
    localparam logic [31:0] FP_INF  = 32'h7F80_0000;

    function automatic logic is_nan(logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(logic [31:0] x);
        return x[30:0] == FP_INF[30:0];
    endfunction

    function automatic logic is_zero(logic [31:0] x);
        return x[30:0] == 31'd0;
    endfunction

    function automatic logic [31:0] order_key(logic [31:0] x);
        logic [31:0] y;
        y = is_zero(x) ? 32'd0 : x;
        return y[31] ? ~y : (y | 32'h8000_0000);
    endfunction

    // e is the biased exponent for a mantissa with its top bit at bit 23
    function automatic logic [31:0] round_pack(logic sgn, logic signed [10:0] e,
                                               logic [23:0] m, logic g, logic st);
        logic [31:0] body;
        logic        rnd;
        rnd  = g & (st | m[0]);
        body = {1'b0, (m[23] ? e[7:0] : 8'd0), m[22:0]} + {31'd0, rnd};
        if (e >= 11'sd255 || body >= FP_INF) begin
            return {sgn, FP_INF[30:0]};
        end
        return {sgn, body[30:0]};
    endfunction

    function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
        logic [7:0]         ea, eb, eh, el, d;
        logic [23:0]        ma, mb, mh, ml;
        logic               sh, sl, swap;
        logic [27:0]        xa, xb0, xb, mask, sum, sn;
        logic [4:0]         p, lz;
        logic signed [10:0] e;
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma = {a[30:23] != 8'd0, a[22:0]};
        mb = {b[30:23] != 8'd0, b[22:0]};
        if (is_nan(a) || is_nan(b)) return FP_QNAN;
        if (is_inf(a) && is_inf(b)) return (a[31] == b[31]) ? a : FP_QNAN;
        if (is_inf(a)) return a;
        if (is_inf(b)) return b;
        if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'd0};
        if (is_zero(a)) return b;
        if (is_zero(b)) return a;
        swap = {ea, ma} < {eb, mb};
        eh = swap ? eb : ea;
        mh = swap ? mb : ma;
        sh = swap ? b[31] : a[31];
        el = swap ? ea : eb;
        ml = swap ? ma : mb;
        sl = swap ? a[31] : b[31];
        if (sh != sl && eh == el && mh == ml) return FP_ZERO;
        d    = eh - el;
        xa   = {1'b0, mh, 3'b000};
        xb0  = {1'b0, ml, 3'b000};
        if (d >= 8'd27) begin
            xb = {27'd0, |ml};
        end else begin
            mask = ~(28'hFFF_FFFF << d[4:0]);
            xb   = (xb0 >> d[4:0]) | {27'd0, |(xb0 & mask)};
        end
        sum = (sh == sl) ? xa + xb : xa - xb;
        p = 5'd0;
        for (int i = 0; i < 28; i++) begin
            if (sum[i]) p = 5'(i);
        end
        if (sum[27]) begin
            sn = {1'b0, sum[27:1]} | {27'd0, sum[0]};
            e  = $signed({3'b000, eh}) + 11'sd1;
        end else begin
            lz = 5'd26 - p;
            if ({3'b000, lz} > eh - 8'd1) lz = 5'(eh - 8'd1);
            sn = sum << lz;
            e  = $signed({3'b000, eh}) - $signed({6'd0, lz});
        end
        return round_pack(sh, e, sn[26:3], sn[2], |sn[1:0]);
    endfunction

    function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
        logic               s;
        logic [7:0]         ea, eb;
        logic [23:0]        ma, mb;
        logic [47:0]        prod, pn, mask;
        logic [5:0]         p, lz;
        logic signed [10:0] fe, k;
        s  = a[31] ^ b[31];
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma = {a[30:23] != 8'd0, a[22:0]};
        mb = {b[30:23] != 8'd0, b[22:0]};
        if (is_nan(a) || is_nan(b)) return FP_QNAN;
        if (is_inf(a) || is_inf(b)) begin
            if (is_zero(a) || is_zero(b)) return FP_QNAN;
            return {s, FP_INF[30:0]};
        end
        if (is_zero(a) || is_zero(b)) return {s, 31'd0};
        prod = ma * mb;
        p = 6'd0;
        for (int i = 0; i < 48; i++) begin
            if (prod[i]) p = 6'(i);
        end
        lz = 6'd47 - p;
        pn = prod << lz;
        fe = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd126
             - $signed({5'd0, lz});
        if (fe < 11'sd1) begin
            k = 11'sd1 - fe;
            if (k >= 11'sd48) begin
                pn = {47'd0, |pn};
            end else begin
                mask = ~(48'hFFFF_FFFF_FFFF << k[5:0]);
                pn   = (pn >> k[5:0]) | {47'd0, |(pn & mask)};
            end
            fe = 11'sd0;
        end
        return round_pack(s, fe, pn[47:24], pn[23], |pn[22:0]);
    endfunction

endpackage

>>> hdl/elementwise_float_alu_unit.sv
// path: an accepted input goes through the input register, then the result register, to result valid
// throughput: one item per cycle unless i_stall holds a valid result, binary32 add and
// multiply each in one pass between the input register and the result register
// reset: valid flags clear, payload registers keep their contents
// ----------------------------------------------------------------------------
// elementwise_float_alu_unit
// elementwise binary32 alu: add, sub, mul, compares, logic ops and select
// ----------------------------------------------------------------------------
module elementwise_float_alu_unit
    import efalu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_func,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    input  logic [31:0] i_operand_mask,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_result
);

    logic        r_in_vld, n_in_vld;
    logic        r_out_vld, n_out_vld;
    logic [3:0]  r_func;
    logic [31:0] r_a, r_b, r_mask;
    logic [31:0] r_result, n_result;
    logic        w_en;

    assign w_en    = !(r_out_vld && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_out_vld;
    assign o_result = r_result;

    assign n_in_vld  = w_en ? i_valid : r_in_vld;
    assign n_out_vld = w_en ? r_in_vld : r_out_vld;

    always_comb begin
        case (r_func)
            FUNC_ADD: n_result = fp_add(r_a, r_b);
            FUNC_SUB: n_result = fp_add(r_a, r_b ^ 32'h8000_0000);
            FUNC_MUL: n_result = fp_mul(r_a, r_b);
            FUNC_LT:  n_result = (!is_nan(r_a) && !is_nan(r_b) &&
                                  order_key(r_a) < order_key(r_b)) ? FP_ONE : FP_ZERO;
            FUNC_GT:  n_result = (!is_nan(r_a) && !is_nan(r_b) &&
                                  order_key(r_b) < order_key(r_a)) ? FP_ONE : FP_ZERO;
            FUNC_EQ:  n_result = (!is_nan(r_a) && !is_nan(r_b) &&
                                  order_key(r_a) == order_key(r_b)) ? FP_ONE : FP_ZERO;
            FUNC_AND: n_result = (!is_zero(r_a) && !is_zero(r_b)) ? FP_ONE : FP_ZERO;
            FUNC_OR:  n_result = (!is_zero(r_a) || !is_zero(r_b)) ? FP_ONE : FP_ZERO;
            FUNC_NOT: n_result = is_zero(r_a) ? FP_ONE : FP_ZERO;
            FUNC_SEL: n_result = !is_zero(r_mask) ? r_a : r_b;
            default:  n_result = FP_ZERO;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_func   <= i_func;
            r_a      <= i_operand_a;
            r_b      <= i_operand_b;
            r_mask   <= i_operand_mask;
            r_result <= n_result;
        end
    end

endmodule
